>>> rtl/lpms_pkg.sv
package lpms_pkg;

  // Number of slots that take part in one set. Slots past this count are skipped.
  localparam int NUM_SLOTS = 8;
  // Width of one coordinate, two's complement.
  localparam int COORD_BITS = 16;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // Widths of the result fields on the output port.
  localparam int BEST_SLOT_W = 3;
  localparam int TIE_MASK_W  = 8;

  // The sort key of one coordinate is its magnitude, followed by the value in offset binary.
  // Comparing the keys as unsigned numbers gives the magnitude-then-value order. The three
  // keys are concatenated with coordinate a most significant, so that a single compare
  // orders whole points.
  localparam int KEY_W   = 2 * COORD_BITS + 1;
  localparam int POINT_W = 3 * KEY_W;

  typedef logic [KEY_W-1:0]     coord_key_t;
  typedef logic [POINT_W-1:0]   point_key_t;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic       present;
    logic       last;
    point_key_t key;
  } slot_t;

  typedef struct packed {
    logic [BEST_SLOT_W-1:0] best_slot;
    logic                   none_found;
    logic [TIE_MASK_W-1:0]  tie_mask;
  } result_t;

  function automatic coord_key_t coord_key(logic signed [COORD_BITS-1:0] v);
    logic [COORD_BITS:0] ext;
    logic [COORD_BITS:0] m;
    ext = {v[COORD_BITS-1], v};
    m   = ext[COORD_BITS] ? ((COORD_BITS + 1)'(0) - ext) : ext;
    return {m, ~v[COORD_BITS-1], v[COORD_BITS-2:0]};
  endfunction

endpackage

>>> rtl/lpms_track.sv
module lpms_track (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lpms_pkg::slot_t  slot,
  output lpms_pkg::result_t result
);

  lpms_pkg::point_key_t best_key_r, best_key_nxt;
  logic [lpms_pkg::IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic have_best_r, have_best_nxt;
  logic [lpms_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  lpms_pkg::slot_mask_t mask_r, mask_nxt;

  logic in_range;
  logic [lpms_pkg::IDX_W-1:0] idx;
  lpms_pkg::slot_mask_t idx_bit;
  logic take;
  logic new_best;
  logic tie;

  assign in_range = cnt_r < lpms_pkg::CNT_W'(lpms_pkg::NUM_SLOTS);
  assign idx      = cnt_r[lpms_pkg::IDX_W-1:0];
  assign idx_bit  = lpms_pkg::slot_mask_t'(1) << idx;
  assign take     = fire && in_range && slot.present;
  assign new_best = take && (!have_best_r || (slot.key < best_key_r));
  assign tie      = take && have_best_r && (slot.key == best_key_r);

  always_comb begin
    have_best_nxt = have_best_r | take;
    best_key_nxt  = new_best ? slot.key : best_key_r;
    best_idx_nxt  = new_best ? idx : best_idx_r;
    if (new_best) begin
      mask_nxt = idx_bit;
    end else if (tie) begin
      mask_nxt = mask_r | idx_bit;
    end else begin
      mask_nxt = mask_r;
    end
    cnt_nxt = (fire && in_range) ? cnt_r + 1'b1 : cnt_r;
  end

  // The result reflects the set including the current slot.
  always_comb begin
    result.none_found = !have_best_nxt;
    result.best_slot  = have_best_nxt ? lpms_pkg::BEST_SLOT_W'(best_idx_nxt) : '0;
    result.tie_mask   = have_best_nxt ? lpms_pkg::TIE_MASK_W'(mask_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      best_idx_r  <= '0;
      cnt_r       <= '0;
      mask_r      <= '0;
    end else if (fire && slot.last) begin
      have_best_r <= 1'b0;
      best_idx_r  <= '0;
      cnt_r       <= '0;
      mask_r      <= '0;
    end else if (fire) begin
      have_best_r <= have_best_nxt;
      best_idx_r  <= best_idx_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_key_r <= best_key_nxt;
  end

  a_mask_set_with_best: assert property (@(posedge clk) disable iff (!rst_n)
    have_best_r |-> (mask_r != '0))
    else $error("tie mask empty while a minimum is held");

  a_mask_clear_without_best: assert property (@(posedge clk) disable iff (!rst_n)
    !have_best_r |-> (mask_r == '0))
    else $error("tie mask set while no minimum is held");

  a_best_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    have_best_r |-> mask_r[best_idx_r])
    else $error("minimum slot missing from its own tie mask");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && slot.last) |=> (cnt_r == '0 && !have_best_r))
    else $error("state not cleared after the last slot");

endmodule

>>> rtl/lattice_point_min_select.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  slot_present, coord_a, coord_b, coord_c, last_slot
// out_     output     out_valid/out_stall best_slot, none_found, tie_mask
//
// One slot word is taken per cycle while in_stall is low; a word is held in the input register and its
// result, if it is the last slot of a set, is loaded into the output register as the word leaves it.
// The point compare is a single unsigned compare of precomputed sort keys, so the minimum
// state is updated each cycle that a word advances, and words may follow back to back.
// Reset (rst_n low at a clock edge) empties both registers and clears the running minimum.
// Only a last-slot word waits on a full, stalled output register; other words pass freely.
module lattice_point_min_select (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_slot_present,
  input  logic signed [lpms_pkg::COORD_BITS-1:0] in_coord_a,
  input  logic signed [lpms_pkg::COORD_BITS-1:0] in_coord_b,
  input  logic signed [lpms_pkg::COORD_BITS-1:0] in_coord_c,
  input  logic                                   in_last_slot,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lpms_pkg::BEST_SLOT_W-1:0]       out_best_slot,
  output logic                                   out_none_found,
  output logic [lpms_pkg::TIE_MASK_W-1:0]        out_tie_mask
);

  // Input register. The sort key of each coordinate is formed here, ahead of the compare.
  logic            s1_valid_r, s1_valid_nxt;
  lpms_pkg::slot_t s1_slot_r, s1_slot_nxt;
  logic            in_take;
  logic            s1_adv;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  lpms_pkg::result_t out_res_r;
  lpms_pkg::result_t res;

  // The held word moves on unless it would produce a result that has nowhere to go.
  assign s1_adv   = s1_valid_r && !(s1_slot_r.last && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt        = in_take || (s1_valid_r && !s1_adv);
    s1_slot_nxt.present = in_slot_present;
    s1_slot_nxt.last    = in_last_slot;
    s1_slot_nxt.key     = {lpms_pkg::coord_key(in_coord_a),
                           lpms_pkg::coord_key(in_coord_b),
                           lpms_pkg::coord_key(in_coord_c)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_slot_r <= s1_slot_nxt;
    end
  end

  lpms_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .slot   (s1_slot_r),
    .result (res)
  );

  // A last slot loads a result; otherwise the register empties once its word is taken.
  always_comb begin
    if (s1_adv && s1_slot_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_slot_r.last) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_slot  = out_res_r.best_slot;
  assign out_none_found = out_res_r.none_found;
  assign out_tie_mask   = out_res_r.tie_mask;

  a_last_waits_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_slot_r.last && out_valid_r && out_stall) |-> (in_stall && !s1_adv))
    else $error("last slot advanced into a stalled output register");

  a_result_from_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_adv && s1_slot_r.last))
    else $error("result appeared without a last slot");

  a_none_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.none_found) |-> (out_res_r.tie_mask == '0 &&
                                               out_res_r.best_slot == '0))
    else $error("empty set reported with a slot or a mask");

endmodule
